/* hdl/fpst_pkg.sv */
// Shared types and codes for the Fenwick prefix-sum table.
package fpst_pkg;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SIZE_W  = 11;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_PREFIX = 2'd1;
    localparam logic [1:0] OP_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         second_index;
        logic signed [DATA_W-1:0] delta;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] total;
        logic                     status;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADD,
        ST_SUM_HI,
        ST_SUM_LO,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load_first;
        logic load_second;
        logic load_low;
        logic step_up;
        logic step_down;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic empty;
        logic is_add;
        logic is_prefix;
        logic is_range;
        logic walk_live;
        logic first_zero;
        logic slot_free;
    } sts_t;

endpackage

/* hdl/fpst_ctrl.sv */
// Controller state machine for the Fenwick prefix-sum table.
module fpst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  fpst_pkg::sts_t sts,
    output fpst_pkg::cmd_t cmd,
    output logic          req_stall
);
    import fpst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.bad)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.is_add)
                begin
                    state_next = ST_ADD;
                end
                else if (sts.is_prefix || (sts.is_range && !sts.empty))
                begin
                    state_next = ST_SUM_HI;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ADD:
            begin
                if (!sts.walk_live)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SUM_HI:
            begin
                if (!sts.walk_live)
                begin
                    if (sts.is_range && !sts.first_zero)
                    begin
                        state_next = ST_SUM_LO;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SUM_LO:
            begin
                if (!sts.walk_live)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_DECODE:
            begin
                if (!sts.bad)
                begin
                    cmd.load_first  = sts.is_add || sts.is_prefix;
                    cmd.load_second = sts.is_range && !sts.empty;
                end
            end
            ST_ADD:
            begin
                cmd.step_up = sts.walk_live;
            end
            ST_SUM_HI:
            begin
                cmd.step_down = sts.walk_live;
                // Second pass subtracts the prefix that ends just below the range start.
                cmd.load_low  = !sts.walk_live && sts.is_range && !sts.first_zero;
            end
            ST_SUM_LO:
            begin
                cmd.step_down = sts.walk_live;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/fpst_dp.sv */
// Datapath for the Fenwick prefix-sum table: node store, walk index, accumulator, result register.
module fpst_dp #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpst_pkg::cmd_t                  cmd,
    output fpst_pkg::sts_t                  sts,
    input  fpst_pkg::item_t                 req_data,
    input  logic                            cfg_valid,
    input  logic [fpst_pkg::SIZE_W-1:0]     cfg_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output fpst_pkg::result_t               rsp_data
);
    import fpst_pkg::*;

    localparam int unsigned AW   = $clog2(MAX_ENTRIES);
    localparam int unsigned NW   = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SW   = (NW > SIZE_W) ? NW : SIZE_W;
    localparam int unsigned CW   = SW + 1;

    logic [DATA_W-1:0] mem [MAX_ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    item_t             item_reg;
    logic [SIZE_W-1:0] active_size_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     k_next;
    logic [AW-1:0]     pend_addr_reg;
    logic              pend_reg;
    logic              neg_reg;
    logic              neg_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    result_t           rsp_data_reg;

    logic [SW-1:0]     size_ext;
    logic [SW-1:0]     n_eff;
    logic [SW-1:0]     first_ext;
    logic [SW-1:0]     second_ext;
    logic              first_out;
    logic              second_out;
    logic [CW-1:0]     low_bit;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;

    assign size_ext   = SW'(active_size_reg);
    assign n_eff      = (size_ext > SW'(MAX_ENTRIES)) ? SW'(MAX_ENTRIES) : size_ext;
    assign first_ext  = SW'(item_reg.first_index);
    assign second_ext = SW'(item_reg.second_index);
    assign first_out  = (first_ext >= n_eff);
    assign second_out = (second_ext >= n_eff);

    assign low_bit = k_reg & (~k_reg + CW'(1));
    assign rd_addr = AW'(k_reg - CW'(1));

    always_comb
    begin
        sts            = '0;
        sts.clear_last = (clr_cnt_reg == AW'(MAX_ENTRIES - 1));
        sts.is_add     = (item_reg.opcode == OP_ADD);
        sts.is_prefix  = (item_reg.opcode == OP_PREFIX);
        sts.is_range   = (item_reg.opcode == OP_RANGE);
        unique case (item_reg.opcode) inside
            OP_ADD, OP_PREFIX: sts.bad = first_out;
            OP_RANGE:          sts.bad = first_out || second_out;
            default:           sts.bad = 1'b0;
        endcase
        sts.empty      = (item_reg.first_index > item_reg.second_index);
        sts.walk_live  = (k_reg != '0) && (k_reg <= CW'(n_eff));
        sts.first_zero = (item_reg.first_index == '0);
        sts.slot_free  = !rsp_valid_reg || !rsp_stall;
    end

    // Node store: clearing pass or add write-back on the write side, walk reads on the other.
    always_comb
    begin
        we    = cmd.clear || (pend_reg && (item_reg.opcode == OP_ADD));
        waddr = cmd.clear ? clr_cnt_reg : pend_addr_reg;
        wdata = cmd.clear ? '0 : (rdata_reg + DATA_W'(item_reg.delta));
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.step_up || cmd.step_down)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        clr_cnt_next = cmd.clear ? (clr_cnt_reg + AW'(1)) : clr_cnt_reg;

        k_next = k_reg;
        if (cmd.load_first)
        begin
            k_next = CW'(item_reg.first_index) + CW'(1);
        end
        else if (cmd.load_second)
        begin
            k_next = CW'(item_reg.second_index) + CW'(1);
        end
        else if (cmd.load_low)
        begin
            k_next = CW'(item_reg.first_index);
        end
        else if (cmd.step_up)
        begin
            k_next = k_reg + low_bit;
        end
        else if (cmd.step_down)
        begin
            k_next = k_reg - low_bit;
        end

        neg_next = neg_reg;
        if (cmd.accept)
        begin
            neg_next = 1'b0;
        end
        else if (cmd.load_low)
        begin
            neg_next = 1'b1;
        end

        // Fold in the node read on the previous cycle.
        acc_next = acc_reg;
        if (cmd.accept)
        begin
            acc_next = '0;
        end
        else if (pend_reg && (item_reg.opcode != OP_ADD))
        begin
            acc_next = neg_reg ? (acc_reg - rdata_reg) : (acc_reg + rdata_reg);
        end

        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= SIZE_W'(1024);
            clr_cnt_reg     <= '0;
            pend_reg        <= 1'b0;
            neg_reg         <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                active_size_reg <= cfg_data;
            end
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= cmd.step_up || cmd.step_down;
            neg_reg       <= neg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_data;
        end
        if (cmd.finish)
        begin
            rsp_data_reg.total  <= (sts.bad || (item_reg.opcode == OP_ADD)) ? '0 : acc_reg;
            rsp_data_reg.status <= sts.bad;
        end
        pend_addr_reg <= rd_addr;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

/* hdl/fenwick_prefix_sum_table.sv */
// Top level of the Fenwick prefix-sum table: controller plus datapath.
//
//  channel  signals                          beat
//  req      req_valid / req_stall / req_data  one operation (item_t)
//  rsp      rsp_valid / rsp_stall / rsp_data  one result (result_t)
//  cfg      cfg_valid / cfg_ready / cfg_data  active size write, always ready
//
// Each item walks v tree nodes after acceptance, one per cycle through the single read
// port: up to log2(MAX_ENTRIES)+1 for add, log2(MAX_ENTRIES) for prefix sum, twice that for
// range sum, which walks a second path unless its first index is zero. Flagged, empty-range
// and unused items skip the walk. The controller returns to idle after each result.
// After reset a clearing pass zeroes the store, one node per cycle; req is stalled during
// it. A new beat is taken while the previous result waits on rsp_stall.
module fenwick_prefix_sum_table #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  fpst_pkg::item_t              req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output fpst_pkg::result_t            rsp_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fpst_pkg::SIZE_W-1:0]  cfg_data
);
    import fpst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fpst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    fpst_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

/* tb/tb_fenwick_prefix_sum_table.sv */
// Self-checking testbench for the Fenwick prefix-sum table: table-driven and random traffic.
module tb_fenwick_prefix_sum_table;
    timeunit 1ns;
    timeprecision 1ps;

    import fpst_pkg::*;

    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int unsigned RANDOM_OPS  = 1650;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic       STS_OK    = 1'b0;
    localparam logic       STS_BAD   = 1'b1;

    typedef struct {
        bit              is_cfg;
        logic [SIZE_W-1:0] size;
        item_t           op;
        bit              fixed;
        result_t         want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    item_t             req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    result_t           rsp_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;

    // shadow Fenwick tree, nodes are 1-based
    logic [DATA_W-1:0] fen_nodes [1:MAX_ENTRIES];
    logic [SIZE_W-1:0] fen_size;

    result_t     sums_due [$];
    plan_row_t   plan [$];
    int unsigned bad_beats;
    int unsigned cycles;
    int unsigned burst_left;
    int unsigned ops_sent;
    bit          hold_armed;

    fenwick_prefix_sum_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned live_size();
        return (fen_size > MAX_ENTRIES) ? MAX_ENTRIES : int'(fen_size);
    endfunction

    function automatic logic [DATA_W-1:0] fen_prefix(int unsigned idx);
        logic [DATA_W-1:0] s;
        int unsigned       k;
        s = '0;
        for (k = idx + 1; k > 0; k -= (k & (~k + 1)))
            s += fen_nodes[k];
        return s;
    endfunction

    function automatic result_t fen_apply(item_t op);
        int unsigned       n;
        int unsigned       a;
        int unsigned       b;
        int unsigned       k;
        logic [DATA_W-1:0] sum;
        result_t           r;
        n = live_size();
        a = int'(op.first_index);
        b = int'(op.second_index);
        r.total  = '0;
        r.status = STS_OK;
        case (op.opcode)
            OP_ADD:
            begin
                if (a >= n)
                    r.status = STS_BAD;
                else
                    for (k = a + 1; k <= n; k += (k & (~k + 1)))
                        fen_nodes[k] += op.delta;
            end
            OP_PREFIX:
            begin
                if (a >= n)
                    r.status = STS_BAD;
                else
                    r.total = fen_prefix(a);
            end
            OP_RANGE:
            begin
                // both ends are checked even for an empty range
                if (a >= n || b >= n)
                    r.status = STS_BAD;
                else if (a <= b)
                begin
                    sum = fen_prefix(b);
                    if (a > 0)
                        sum -= fen_prefix(a - 1);
                    r.total = sum;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic item_t random_op();
        item_t             it;
        int unsigned       pick;
        logic [IDX_W-1:0]  swap;
        pick = $urandom_range(0, 99);
        it.opcode = (pick < 40) ? OP_ADD : (pick < 65) ? OP_PREFIX :
                    (pick < 95) ? OP_RANGE : OP_UNUSED;
        it.first_index  = pick_index(live_size());
        it.second_index = pick_index(live_size());
        if ($urandom_range(0, 3) == 0)
            it.delta = int'($urandom_range(0, 200)) - 100;
        else
            it.delta = $urandom;
        // keep most ranges ordered so they actually sum something
        if (it.opcode == OP_RANGE && it.first_index > it.second_index
            && $urandom_range(0, 3) != 0)
        begin
            swap            = it.first_index;
            it.first_index  = it.second_index;
            it.second_index = swap;
        end
        return it;
    endfunction

    function automatic plan_row_t op_row(logic [1:0] opc, int unsigned a, int unsigned b,
                                         logic [DATA_W-1:0] d, bit fixed,
                                         logic [DATA_W-1:0] tot, logic st);
        plan_row_t row;
        row.is_cfg          = 1'b0;
        row.size            = '0;
        row.op.opcode       = opc;
        row.op.first_index  = IDX_W'(a);
        row.op.second_index = IDX_W'(b);
        row.op.delta        = d;
        row.fixed           = fixed;
        row.want.total      = tot;
        row.want.status     = st;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [SIZE_W-1:0] size);
        plan_row_t row;
        row        = op_row(OP_UNUSED, 0, 0, '0, 1'b0, '0, STS_OK);
        row.is_cfg = 1'b1;
        row.size   = size;
        return row;
    endfunction

    function automatic void add_row(plan_row_t row);
        plan = {plan, row};
    endfunction

    task automatic note_bad(input string why);
        bad_beats++;
        if (bad_beats <= 10)
            $display("%s", why);
    endtask

    // Offer one beat, in bursts with random gaps unless gaps are suppressed.
    task automatic offer_op(input item_t op, input bit no_gaps, input bit fixed,
                            input result_t want);
        int unsigned gap;
        result_t     due;
        gap = 0;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= op;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        if (burst_left > 0)
            burst_left--;
        due = fen_apply(op);
        if (fixed)
            due = want;
        sums_due = {sums_due, due};
    endtask

    // Drop valid and hold until every outstanding sum has come back.
    task automatic end_burst();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sums_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        fen_size = size;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (sums_due.size() == 0)
                note_bad($sformatf("unexpected result beat: total %h status %b",
                                   rsp_data.total, rsp_data.status));
            else
            begin
                want = sums_due.pop_front();
                if (rsp_data.total !== want.total || rsp_data.status !== want.status)
                    note_bad($sformatf("result mismatch: total %h status %b, expected %h %b",
                                       rsp_data.total, rsp_data.status,
                                       want.total, want.status));
            end
        end
    end

    // Receiver back-pressure: segments of no stall, light or heavy stall, plus one long hold.
    initial
    begin : rsp_pattern
        int unsigned seg;
        int unsigned mode;
        rsp_stall = 1'b0;
        forever
        begin
            if (hold_armed)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_armed = 1'b0;
            end
            else
            begin
                seg  = $urandom_range(10, 60);
                mode = $urandom_range(0, 2);
                repeat (seg)
                begin
                    case (mode)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 2) == 0);
                        default: rsp_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned       phase;
        int unsigned       burst_ops;
        bit                pressure;
        logic [SIZE_W-1:0] size;
        result_t           none;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        bad_beats  = 0;
        cycles     = 0;
        burst_left = 0;
        ops_sent   = 0;
        hold_armed = 1'b0;
        none       = '0;
        fen_size   = SIZE_W'(MAX_ENTRIES);
        for (int i = 1; i <= MAX_ENTRIES; i++)
            fen_nodes[i] = '0;

        // cleared store, full size
        add_row(op_row(OP_PREFIX, 0, 0, '0, 1'b1, '0, STS_OK));
        add_row(op_row(OP_PREFIX, 1023, 0, '0, 1'b1, '0, STS_OK));
        add_row(op_row(OP_RANGE, 0, 1023, '0, 1'b1, '0, STS_OK));
        add_row(op_row(OP_ADD, 0, 0, 32'h7FFF_FFFF, 1'b1, '0, STS_OK));
        add_row(op_row(OP_ADD, 1023, 0, 32'h8000_0000, 1'b1, '0, STS_OK));
        add_row(op_row(OP_ADD, 511, 0, 32'hFFFF_FFFF, 1'b1, '0, STS_OK));
        add_row(op_row(OP_PREFIX, 0, 0, '0, 1'b1, 32'h7FFF_FFFF, STS_OK));
        add_row(op_row(OP_PREFIX, 1023, 0, '0, 1'b0, '0, STS_OK));
        add_row(op_row(OP_RANGE, 1023, 1023, '0, 1'b0, '0, STS_OK));
        // empty ranges
        add_row(op_row(OP_RANGE, 5, 3, '0, 1'b1, '0, STS_OK));
        add_row(op_row(OP_RANGE, 1023, 0, '0, 1'b1, '0, STS_OK));
        // unused opcode with junk fields
        add_row(op_row(OP_UNUSED, 1023, 1023, 32'hFFFF_FFFF, 1'b1, '0, STS_OK));
        // second index is ignored by add and prefix
        add_row(op_row(OP_ADD, 700, 1023, 32'd12345, 1'b1, '0, STS_OK));
        add_row(op_row(OP_PREFIX, 700, 1023, '0, 1'b0, '0, STS_OK));
        add_row(op_row(OP_RANGE, 0, 0, '0, 1'b0, '0, STS_OK));
        add_row(op_row(OP_RANGE, 1, 511, '0, 1'b0, '0, STS_OK));
        // shrink: store is kept, out-of-range indices are flagged
        add_row(cfg_row(11'd600));
        add_row(op_row(OP_ADD, 600, 0, 32'd1, 1'b1, '0, STS_BAD));
        add_row(op_row(OP_PREFIX, 1023, 0, '0, 1'b1, '0, STS_BAD));
        add_row(op_row(OP_RANGE, 0, 600, '0, 1'b1, '0, STS_BAD));
        add_row(op_row(OP_RANGE, 600, 0, '0, 1'b1, '0, STS_BAD));
        add_row(op_row(OP_PREFIX, 599, 0, '0, 1'b0, '0, STS_OK));
        add_row(op_row(OP_RANGE, 100, 599, '0, 1'b0, '0, STS_OK));
        // zero size flags everything
        add_row(cfg_row(11'd0));
        add_row(op_row(OP_PREFIX, 0, 0, '0, 1'b1, '0, STS_BAD));
        add_row(op_row(OP_ADD, 0, 0, 32'd7, 1'b1, '0, STS_BAD));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                end_burst();
                write_size(plan[i].size);
            end
            else
                offer_op(plan[i].op, 1'b0, plan[i].fixed, plan[i].want);
        end
        end_burst();

        phase = 0;
        while (ops_sent < RANDOM_OPS)
        begin
            case (phase % 8)
                0: size = 11'd1;
                1: size = 11'd2047;
                2: size = SIZE_W'(MAX_ENTRIES);
                3: size = 11'd2;
                4: size = 11'd0;
                5: size = 11'd1025;
                default: size = SIZE_W'($urandom_range(1, MAX_ENTRIES));
            endcase
            write_size(size);
            pressure  = (phase == 2);
            burst_ops = pressure ? 160 : (size == 0) ? 20 : $urandom_range(60, 180);
            if (burst_ops > RANDOM_OPS - ops_sent)
                burst_ops = RANDOM_OPS - ops_sent;
            // long receiver hold while the sender keeps pushing back to back
            if (pressure)
                hold_armed = 1'b1;
            repeat (burst_ops)
                offer_op(random_op(), pressure, 1'b0, none);
            ops_sent += burst_ops;
            end_burst();
            phase++;
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (bad_beats == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
